// ----- design/sri_pkg.sv -----
// Shared types, constants and helper functions for the segment/rectangle
// intersection unit. No dependencies; every other design file imports it.

package sri_pkg;

    localparam int NUM_EDGES   = 4;
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_TOP    = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_BOTTOM = 3;

    // One quotient bit per divider stage; a hit quotient always fits 16 bits.
    localparam int DIV_STEPS   = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [15:0] t_coord;
    typedef logic signed [16:0] t_diff;
    typedef logic signed [33:0] t_prod;
    typedef logic signed [34:0] t_wide;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        t_coord rect_left;
        t_coord rect_top;
        t_coord rect_right;
        t_coord rect_bottom;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [2:0] hit_count;
        t_coord     first_x;
        t_coord     first_y;
        t_coord     second_x;
        t_coord     second_y;
        t_coord     near_x;
        t_coord     near_y;
    } t_res;

    // Per-item context that rides alongside the dividers.
    typedef struct packed {
        t_coord                     px;
        t_coord                     py;
        t_coord                     rect_left;
        t_coord                     rect_top;
        t_coord                     rect_right;
        t_coord                     rect_bottom;
        logic [NUM_EDGES-1:0]       hit;
        logic [NUM_EDGES-1:0][15:0] off;
    } t_ctx;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        t_ctx                       ctx;
        logic [NUM_EDGES-1:0][31:0] num_mag;
        logic [NUM_EDGES-1:0][15:0] div_mag;
        logic [NUM_EDGES-1:0]       neg;
    } t_job;

    // True when num/den lies in the closed interval [0,1].
    function automatic logic in_unit(t_wide num, t_wide den);
        logic ok;
        if (den > 0) begin
            ok = (num >= 0) && (num <= den);
        end else begin
            ok = (num <= 0) && (num >= den);
        end
        return ok;
    endfunction

    function automatic logic [15:0] abs_diff(t_diff v);
        t_diff m;
        m = v[16] ? -v : v;
        return m[15:0];
    endfunction

    function automatic logic [31:0] abs_prod(t_prod v);
        t_prod m;
        m = v[33] ? -v : v;
        return m[31:0];
    endfunction

endpackage

// ----- design/segment_rect_intersect_unit.sv -----
// Top level of the segment/rectangle intersection unit: front end, item
// queue and back end. Depends on sri_pkg, sri_front, sri_queue, sri_back.
//
//   channel | ports                      | transfer when
//   --------+----------------------------+--------------------
//   input   | i_push, o_full, i_item     | i_push && !o_full
//   result  | o_empty, i_pop, o_result   | i_pop && !o_empty
//
// While neither side stalls, one item is taken every clock cycle and one result
// leaves every cycle. Each item passes three front stages, the item queue,
// sixteen divider stages (one quotient bit each), a finish stage and the result buffer.
// Reset is synchronous and empties both queues and all pipeline valid bits.
// A stalled result side fills the result buffer, then the back end, then the
// item queue; o_full rises only once the front end cannot move.

module segment_rect_intersect_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  sri_pkg::t_in  i_item,
    output logic          o_empty,
    input  logic          i_pop,
    output sri_pkg::t_res o_result
);
    import sri_pkg::*;

    logic w_job_push, w_q_full, w_q_pop, w_q_empty;
    t_job w_job_in, w_job_out;

    sri_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_item     (i_item),
        .o_job_push (w_job_push),
        .o_job      (w_job_in),
        .i_q_full   (w_q_full)
    );

    sri_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_job   (w_job_out),
        .o_empty (w_q_empty)
    );

    sri_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_job   (w_job_out),
        .o_q_pop   (w_q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

endmodule

// ----- design/sri_div.sv -----
// Pipelined rounding divider: one quotient bit per stage, round half away
// from zero on magnitudes. Depends on sri_pkg.

module sri_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_num_mag,
    input  logic [15:0] i_div_mag,
    input  logic        i_neg,
    output logic [15:0] o_quot_mag,
    output logic        o_neg
);
    import sri_pkg::*;

    logic [33:0] w_n;
    logic [16:0] w_d;

    logic [16:0] w_rem_in [DIV_STEPS];
    logic [15:0] w_lo_in  [DIV_STEPS];
    logic [15:0] w_q_in   [DIV_STEPS];
    logic [16:0] w_d_in   [DIV_STEPS];
    logic        w_neg_in [DIV_STEPS];

    logic [16:0] n_rem [DIV_STEPS];
    logic [15:0] n_q   [DIV_STEPS];

    logic [16:0] r_rem [DIV_STEPS];
    logic [15:0] r_lo  [DIV_STEPS];
    logic [15:0] r_q   [DIV_STEPS];
    logic [16:0] r_d   [DIV_STEPS];
    logic        r_neg [DIV_STEPS];

    // Rounded quotient floor((2n + d) / 2d).
    assign w_n = {1'b0, i_num_mag, 1'b0} + 34'(i_div_mag);
    assign w_d = {i_div_mag, 1'b0};

    always_comb begin
        w_rem_in[0] = w_n[32:16];
        w_lo_in[0]  = w_n[15:0];
        w_q_in[0]   = '0;
        w_d_in[0]   = w_d;
        w_neg_in[0] = i_neg;
        for (int j = 1; j < DIV_STEPS; j++) begin
            w_rem_in[j] = r_rem[j-1];
            w_lo_in[j]  = r_lo[j-1];
            w_q_in[j]   = r_q[j-1];
            w_d_in[j]   = r_d[j-1];
            w_neg_in[j] = r_neg[j-1];
        end
    end

    always_comb begin
        logic [17:0] t;
        logic        ge;
        for (int j = 0; j < DIV_STEPS; j++) begin
            t  = {w_rem_in[j], w_lo_in[j][15]};
            ge = (t >= {1'b0, w_d_in[j]});
            n_rem[j] = ge ? 17'(t - {1'b0, w_d_in[j]}) : t[16:0];
            n_q[j]   = {w_q_in[j][14:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_rem[j] <= n_rem[j];
                r_lo[j]  <= {w_lo_in[j][14:0], 1'b0};
                r_q[j]   <= n_q[j];
                r_d[j]   <= w_d_in[j];
                r_neg[j] <= w_neg_in[j];
            end
        end
    end

    assign o_quot_mag = r_q[DIV_STEPS-1];
    assign o_neg      = r_neg[DIV_STEPS-1];

endmodule

// ----- design/sri_front.sv -----
// Front end: takes items, forms edge determinants and classifies each edge
// as hit or miss, then hands division operands to the queue. Uses sri_pkg.

module sri_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  sri_pkg::t_in  i_item,
    output logic          o_job_push,
    output sri_pkg::t_job o_job,
    input  logic          i_q_full
);
    import sri_pkg::*;

    typedef struct packed {
        t_coord px, py, l, t, r, b;
        t_diff  dx, dy, ex, ey, wxl, wxr, wyt, wyb;
    } t_s1;

    typedef struct packed {
        t_coord px, py, l, t, r, b;
        t_prod  pd_v, pd_h;
        t_prod  p_dx_wyt, p_dx_wyb, p_dy_wxl, p_dy_wxr;
        t_prod  p_ey_wxl, p_ey_wxr, p_ex_wyt, p_ex_wyb;
        logic [NUM_EDGES-1:0][15:0] off;
        logic [15:0] mag_dx, mag_dy;
        logic        neg_dx, neg_dy;
    } t_s2;

    typedef struct packed {
        t_coord px, py, l, t, r, b;
        logic [NUM_EDGES-1:0][34:0] den, na, nb;
        logic [NUM_EDGES-1:0][33:0] num;
        logic [NUM_EDGES-1:0][15:0] off, dmag;
        logic [NUM_EDGES-1:0]       dneg;
    } t_s3;

    logic w_adv;
    logic r1_v, r2_v, r3_v;
    t_s1  r1, n1;
    t_s2  r2, n2;
    t_s3  r3, n3;

    assign w_adv      = !(r3_v && i_q_full);
    assign o_full     = !w_adv;
    assign o_job_push = r3_v && !i_q_full;

    always_comb begin
        n1.px  = i_item.start_x;
        n1.py  = i_item.start_y;
        n1.l   = i_item.rect_left;
        n1.t   = i_item.rect_top;
        n1.r   = i_item.rect_right;
        n1.b   = i_item.rect_bottom;
        n1.dx  = 17'(i_item.end_x) - 17'(i_item.start_x);
        n1.dy  = 17'(i_item.end_y) - 17'(i_item.start_y);
        n1.ex  = 17'(i_item.rect_right) - 17'(i_item.rect_left);
        n1.ey  = 17'(i_item.rect_bottom) - 17'(i_item.rect_top);
        n1.wxl = 17'(i_item.rect_left) - 17'(i_item.start_x);
        n1.wxr = 17'(i_item.rect_right) - 17'(i_item.start_x);
        n1.wyt = 17'(i_item.rect_top) - 17'(i_item.start_y);
        n1.wyb = 17'(i_item.rect_bottom) - 17'(i_item.start_y);
    end

    // Offsets are taken from the start point to the edge line, so vertical
    // and horizontal edges share most of their products.
    always_comb begin
        n2.px = r1.px;
        n2.py = r1.py;
        n2.l  = r1.l;
        n2.t  = r1.t;
        n2.r  = r1.r;
        n2.b  = r1.b;
        n2.pd_v     = 34'(r1.ey) * 34'(r1.dx);
        n2.pd_h     = 34'(r1.ex) * 34'(r1.dy);
        n2.p_dx_wyt = 34'(r1.dx) * 34'(r1.wyt);
        n2.p_dx_wyb = 34'(r1.dx) * 34'(r1.wyb);
        n2.p_dy_wxl = 34'(r1.dy) * 34'(r1.wxl);
        n2.p_dy_wxr = 34'(r1.dy) * 34'(r1.wxr);
        n2.p_ey_wxl = 34'(r1.ey) * 34'(r1.wxl);
        n2.p_ey_wxr = 34'(r1.ey) * 34'(r1.wxr);
        n2.p_ex_wyt = 34'(r1.ex) * 34'(r1.wyt);
        n2.p_ex_wyb = 34'(r1.ex) * 34'(r1.wyb);
        n2.off[EDGE_LEFT]   = abs_diff(r1.wxl);
        n2.off[EDGE_TOP]    = abs_diff(r1.wyt);
        n2.off[EDGE_RIGHT]  = abs_diff(r1.wxr);
        n2.off[EDGE_BOTTOM] = abs_diff(r1.wyb);
        n2.mag_dx = abs_diff(r1.dx);
        n2.mag_dy = abs_diff(r1.dy);
        n2.neg_dx = r1.dx[16];
        n2.neg_dy = r1.dy[16];
    end

    // Horizontal edges use the negated determinant and numerators, which
    // leaves the interval tests unchanged.
    always_comb begin
        n3.px = r2.px;
        n3.py = r2.py;
        n3.l  = r2.l;
        n3.t  = r2.t;
        n3.r  = r2.r;
        n3.b  = r2.b;
        n3.off = r2.off;

        n3.den[EDGE_LEFT]   = 35'(r2.pd_v);
        n3.den[EDGE_TOP]    = 35'(r2.pd_h);
        n3.den[EDGE_RIGHT]  = 35'(r2.pd_v);
        n3.den[EDGE_BOTTOM] = 35'(r2.pd_h);

        n3.na[EDGE_LEFT]    = 35'(r2.p_ey_wxl);
        n3.na[EDGE_TOP]     = 35'(r2.p_ex_wyt);
        n3.na[EDGE_RIGHT]   = 35'(r2.p_ey_wxr);
        n3.na[EDGE_BOTTOM]  = 35'(r2.p_ex_wyb);

        n3.nb[EDGE_LEFT]    = 35'(r2.p_dy_wxl) - 35'(r2.p_dx_wyt);
        n3.nb[EDGE_TOP]     = 35'(r2.p_dx_wyt) - 35'(r2.p_dy_wxl);
        n3.nb[EDGE_RIGHT]   = 35'(r2.p_dy_wxr) - 35'(r2.p_dx_wyt);
        n3.nb[EDGE_BOTTOM]  = 35'(r2.p_dx_wyb) - 35'(r2.p_dy_wxl);

        n3.num[EDGE_LEFT]   = r2.p_dy_wxl;
        n3.num[EDGE_TOP]    = r2.p_dx_wyt;
        n3.num[EDGE_RIGHT]  = r2.p_dy_wxr;
        n3.num[EDGE_BOTTOM] = r2.p_dx_wyb;

        n3.dmag[EDGE_LEFT]   = r2.mag_dx;
        n3.dmag[EDGE_TOP]    = r2.mag_dy;
        n3.dmag[EDGE_RIGHT]  = r2.mag_dx;
        n3.dmag[EDGE_BOTTOM] = r2.mag_dy;
        n3.dneg[EDGE_LEFT]   = r2.neg_dx;
        n3.dneg[EDGE_TOP]    = r2.neg_dy;
        n3.dneg[EDGE_RIGHT]  = r2.neg_dx;
        n3.dneg[EDGE_BOTTOM] = r2.neg_dy;
    end

    always_comb begin
        o_job.ctx.px          = r3.px;
        o_job.ctx.py          = r3.py;
        o_job.ctx.rect_left   = r3.l;
        o_job.ctx.rect_top    = r3.t;
        o_job.ctx.rect_right  = r3.r;
        o_job.ctx.rect_bottom = r3.b;
        o_job.ctx.off         = r3.off;
        o_job.div_mag         = r3.dmag;
        for (int e = 0; e < NUM_EDGES; e++) begin
            o_job.ctx.hit[e] = (r3.den[e] != '0) && in_unit(r3.na[e], r3.den[e])
                               && in_unit(r3.nb[e], r3.den[e]);
            o_job.num_mag[e] = abs_prod(r3.num[e]);
            o_job.neg[e]     = r3.num[e][33] ^ r3.dneg[e];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_push;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1 <= n1;
            r2 <= n2;
            r3 <= n3;
        end
    end

endmodule

// ----- design/sri_queue.sv -----
// Short queue of classified items between the front and back ends.
// Depends on sri_pkg for the item type and depth.

module sri_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sri_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output sri_pkg::t_job o_job,
    output logic          o_empty
);
    import sri_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_wr, w_rd;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- design/sri_back.sv -----
// Back end: four pipelined dividers produce the hit points, then the first,
// second and nearer hits are picked into a two-entry result buffer.
// Depends on sri_pkg and sri_div.

module sri_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sri_pkg::t_job i_q_job,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output sri_pkg::t_res o_result
);
    import sri_pkg::*;

    typedef struct packed {
        logic [NUM_EDGES-1:0]       hit;
        logic [NUM_EDGES-1:0][15:0] x;
        logic [NUM_EDGES-1:0][15:0] y;
        logic [NUM_EDGES-1:0][16:0] mdist;
    } t_fin;

    logic w_adv;
    logic r_v   [DIV_STEPS];
    t_ctx r_ctx [DIV_STEPS];
    logic r_fin_v;
    t_fin r_fin, n_fin;

    logic [NUM_EDGES-1:0][15:0] w_qmag;
    logic [NUM_EDGES-1:0]       w_qneg;

    t_res      r_ob [2];
    logic      r_wp, r_rp;
    logic [1:0] r_cnt;
    logic      w_push, w_pop;
    t_res      w_res;

    assign w_adv   = !(r_fin_v && (r_cnt == 2'd2));
    assign o_q_pop = w_adv && !i_q_empty;

    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_div
        sri_div u_div (
            .i_clk      (i_clk),
            .i_en       (w_adv),
            .i_num_mag  (i_q_job.num_mag[e]),
            .i_div_mag  (i_q_job.div_mag[e]),
            .i_neg      (i_q_job.neg[e]),
            .o_quot_mag (w_qmag[e]),
            .o_neg      (w_qneg[e])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_v[j] <= 1'b0;
            end
            r_fin_v <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= !i_q_empty;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_v[j] <= r_v[j-1];
            end
            r_fin_v <= r_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ctx[0] <= i_q_job.ctx;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_ctx[j] <= r_ctx[j-1];
            end
            r_fin <= n_fin;
        end
    end

    // On a vertical edge the hit x is the edge itself and only y is divided;
    // horizontal edges are the mirror case.
    always_comb begin
        t_ctx  c;
        t_diff sq;
        t_diff sum;
        c = r_ctx[DIV_STEPS-1];
        n_fin.hit = c.hit;
        for (int e = 0; e < NUM_EDGES; e++) begin
            sq  = w_qneg[e] ? -t_diff'({1'b0, w_qmag[e]}) : t_diff'({1'b0, w_qmag[e]});
            sum = '0;
            n_fin.x[e] = '0;
            n_fin.y[e] = '0;
            case (e)
                EDGE_LEFT: begin
                    sum = 17'(c.py) + sq;
                    n_fin.x[e] = c.rect_left;
                    n_fin.y[e] = sum[15:0];
                end
                EDGE_RIGHT: begin
                    sum = 17'(c.py) + sq;
                    n_fin.x[e] = c.rect_right;
                    n_fin.y[e] = sum[15:0];
                end
                EDGE_TOP: begin
                    sum = 17'(c.px) + sq;
                    n_fin.x[e] = sum[15:0];
                    n_fin.y[e] = c.rect_top;
                end
                default: begin
                    sum = 17'(c.px) + sq;
                    n_fin.x[e] = sum[15:0];
                    n_fin.y[e] = c.rect_bottom;
                end
            endcase
            n_fin.mdist[e] = 17'(c.off[e]) + 17'(w_qmag[e]);
        end
    end

    always_comb begin
        logic [2:0] cnt;
        logic [1:0] fi, si;
        logic       two;
        cnt = '0;
        fi  = '0;
        si  = '0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            cnt = cnt + 3'(r_fin.hit[e]);
            if (r_fin.hit[e]) begin
                si = 2'(e);
            end
        end
        for (int e = NUM_EDGES - 1; e >= 0; e--) begin
            if (r_fin.hit[e]) begin
                fi = 2'(e);
            end
        end
        two = (cnt >= 3'd2);
        w_res.hit       = (cnt != '0);
        w_res.hit_count = cnt;
        w_res.first_x   = (cnt != '0) ? r_fin.x[fi] : '0;
        w_res.first_y   = (cnt != '0) ? r_fin.y[fi] : '0;
        w_res.second_x  = two ? r_fin.x[si] : '0;
        w_res.second_y  = two ? r_fin.y[si] : '0;
        if (two && (r_fin.mdist[si] < r_fin.mdist[fi])) begin
            w_res.near_x = w_res.second_x;
            w_res.near_y = w_res.second_y;
        end else begin
            w_res.near_x = w_res.first_x;
            w_res.near_y = w_res.first_y;
        end
    end

    assign w_push   = w_adv && r_fin_v;
    assign w_pop    = i_pop && (r_cnt != 2'd0);
    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_ob[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ob[r_wp] <= w_res;
        end
    end

endmodule

// ----- design/sri_checker.sv -----
// Port-level checks for segment_rect_intersect_unit, attached with a bind.
// Depends on sri_pkg and the top-level port list.

module sri_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_push,
    input logic          o_full,
    input sri_pkg::t_in  i_item,
    input logic          o_empty,
    input logic          i_pop,
    input sri_pkg::t_res o_result
);
    import sri_pkg::*;

    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result side not empty after reset");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("waiting result changed before its transfer");

    a_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_result.hit == (o_result.hit_count != 3'd0))
                      && (o_result.hit_count <= 3'd4)))
        else $error("hit flag and hit count disagree");

    a_second : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_result.hit_count < 3'd2)) |->
            ((o_result.second_x == 16'sd0) && (o_result.second_y == 16'sd0)))
        else $error("second hit reported with fewer than two hits");

    a_near : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |->
            (((o_result.near_x == o_result.first_x)
              && (o_result.near_y == o_result.first_y))
             || ((o_result.near_x == o_result.second_x)
              && (o_result.near_y == o_result.second_y))))
        else $error("nearer hit is neither the first nor the second");

    logic w_unused;
    assign w_unused = i_push ^ o_full ^ (^i_item);

endmodule

bind segment_rect_intersect_unit sri_checker u_sri_checker (.*);

// ----- bench/segment_rect_intersect_unit_tb.sv -----
// Testbench for segment_rect_intersect_unit: drives segment/rectangle pairs,
// predicts each result with an exact integer model and checks it. Uses sri_pkg.
`timescale 1ns / 100ps

module segment_rect_intersect_unit_tb;
    import sri_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_push;
    logic o_full;
    t_in  i_item;
    logic o_empty;
    logic i_pop;
    t_res o_result;

    segment_rect_intersect_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    t_in  pending_items[$];
    t_res expected_hits[$];
    int   mismatches;
    int   push_wait;
    int   pop_wait;
    bit   hold_push;
    bit   stim_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Rounded quotient, ties away from zero.
    function automatic longint round_div(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (2 * un + ud) / (2 * ud);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic bit within_unit(longint num, longint den);
        if (den > 0) begin
            return num >= 0 && num <= den;
        end
        return num <= 0 && num >= den;
    endfunction

    function automatic t_res predict_crossing(t_in it);
        t_res   r;
        longint px, py, dx, dy, ex, ey, wx, wy, den, na, nb, ix, iy;
        longint fx, fy, sx, sy, d1, d2;
        longint ax[4], ay[4], bx[4], by[4];
        int     count;
        px = it.start_x;
        py = it.start_y;
        dx = longint'(it.end_x) - px;
        dy = longint'(it.end_y) - py;
        ax = '{it.rect_left, it.rect_left, it.rect_right, it.rect_left};
        ay = '{it.rect_top, it.rect_top, it.rect_top, it.rect_bottom};
        bx = '{it.rect_left, it.rect_right, it.rect_right, it.rect_right};
        by = '{it.rect_bottom, it.rect_top, it.rect_bottom, it.rect_bottom};
        fx = 0; fy = 0; sx = 0; sy = 0;
        count = 0;
        for (int k = 0; k < NUM_EDGES; k++) begin
            ex = bx[k] - ax[k];
            ey = by[k] - ay[k];
            wx = px - ax[k];
            wy = py - ay[k];
            den = ey * dx - ex * dy;
            na = ex * wy - ey * wx;
            nb = dx * wy - dy * wx;
            if (den != 0 && within_unit(na, den) && within_unit(nb, den)) begin
                ix = px + round_div(na * dx, den);
                iy = py + round_div(na * dy, den);
                if (count == 0) begin
                    fx = ix; fy = iy;
                end else begin
                    sx = ix; sy = iy;
                end
                count++;
            end
        end
        r.hit = (count > 0);
        r.hit_count = count[2:0];
        r.first_x = fx[15:0];
        r.first_y = fy[15:0];
        r.second_x = sx[15:0];
        r.second_y = sy[15:0];
        r.near_x = fx[15:0];
        r.near_y = fy[15:0];
        if (count >= 2) begin
            d1 = ((fx < px) ? px - fx : fx - px) + ((fy < py) ? py - fy : fy - py);
            d2 = ((sx < px) ? px - sx : sx - px) + ((sy < py) ? py - sy : sy - py);
            if (d2 < d1) begin
                r.near_x = sx[15:0];
                r.near_y = sy[15:0];
            end
        end
        return r;
    endfunction

    function automatic t_in make_item(int sx, int sy, int ex, int ey,
                                      int l, int t, int r, int b);
        t_in it;
        it.start_x = sx[15:0];
        it.start_y = sy[15:0];
        it.end_x = ex[15:0];
        it.end_y = ey[15:0];
        it.rect_left = l[15:0];
        it.rect_top = t[15:0];
        it.rect_right = r[15:0];
        it.rect_bottom = b[15:0];
        return it;
    endfunction

    function automatic logic [15:0] near_coord(logic [15:0] base, int span);
        int v;
        v = $signed(base) + $signed($urandom_range(2 * span, 0)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Mostly segments that cross a random rectangle, some fully random pairs,
    // and some with coordinates snapped onto edges and corners or made vertical.
    function automatic t_in random_item();
        t_in it;
        int  kind;
        int  span;
        kind = $urandom_range(9, 0);
        it = t_in'({$urandom, $urandom, $urandom, $urandom});
        if (kind < 2) begin
            return it;
        end
        span = (kind < 5) ? 64 : ((kind < 8) ? 2048 : 32767);
        it.rect_left = near_coord(16'd0, span);
        it.rect_right = near_coord(it.rect_left, span);
        it.rect_top = near_coord(16'd0, span);
        it.rect_bottom = near_coord(it.rect_top, span);
        it.start_x = near_coord(it.rect_left, 2 * span);
        it.start_y = near_coord(it.rect_top, 2 * span);
        it.end_x = near_coord(it.rect_right, 2 * span);
        it.end_y = near_coord(it.rect_bottom, 2 * span);
        if (kind == 9) begin
            case ($urandom_range(3, 0))
                0: it.start_x = it.rect_left;
                1: it.end_y = it.rect_bottom;
                2: begin
                    it.start_x = it.rect_left;
                    it.start_y = it.rect_top;
                end
                default: it.end_x = it.start_x;
            endcase
        end
        return it;
    endfunction

    // Driver: one item per transfer, random gaps between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
            push_wait <= 0;
        end else if (i_push && o_full) begin
            // Hold the item until the block takes it.
        end else begin
            if (i_push) begin
                expected_hits.push_back(predict_crossing(i_item));
            end
            if (push_wait > 0) begin
                push_wait <= push_wait - 1;
                i_push <= 1'b0;
            end else if (pending_items.size() > 0 && !hold_push) begin
                i_item <= pending_items.pop_front();
                i_push <= 1'b1;
                push_wait <= $urandom_range(3, 0);
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
            pop_wait <= 0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result %p", o_result);
                    end
                end else if (o_result !== expected_hits[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %p got %p",
                                 expected_hits[0], o_result);
                    end
                    void'(expected_hits.pop_front());
                end else begin
                    void'(expected_hits.pop_front());
                end
            end
            if (i_pop && !o_empty || !i_pop) begin
                if (pop_wait > 0) begin
                    pop_wait <= pop_wait - 1;
                    i_pop <= 1'b0;
                end else begin
                    i_pop <= 1'b1;
                    pop_wait <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(3, 0);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        hold_push = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_item = '0;
        // Directed: field extremes, crossings, corners, parallel and degenerate cases.
        pending_items.push_back(make_item(-32768, -32768, 32767, 32767, -100, -100, 100, 100));
        pending_items.push_back(make_item(32767, 32767, -32768, -32768, 100, 100, -100, -100));
        pending_items.push_back(make_item(-32768, 0, 32767, 0, -32768, -32768, 32767, 32767));
        pending_items.push_back(make_item(-200, 5, 200, 5, -100, -100, 100, 100));
        pending_items.push_back(make_item(-200, -200, 200, 200, -100, -100, 100, 100));
        pending_items.push_back(make_item(-100, -300, -100, 300, -100, -100, 100, 100));
        pending_items.push_back(make_item(-300, -100, 300, -100, -100, -100, 100, 100));
        pending_items.push_back(make_item(5, 5, 5, 5, -100, -100, 100, 100));
        pending_items.push_back(make_item(-300, 7, 300, 9, 0, 0, 0, 0));
        pending_items.push_back(make_item(-300, 7, 300, 9, 50, 50, 50, 200));
        pending_items.push_back(make_item(0, 0, 50, 20, -100, -100, 100, 100));
        pending_items.push_back(make_item(0, 0, 500, 1, -100, -100, 100, 100));
        pending_items.push_back(make_item(-150, -50, 50, 150, 100, 100, -100, -100));
        pending_items.push_back(make_item(300, 300, 400, 500, -100, -100, 100, 100));
        pending_items.push_back(make_item(-1, -3, 1, 3, -1, -1, 1, 1));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_items.push_back(make_item(32767, -32768, -32768, 32767, 32767, -32768,
                                          -32768, 32767));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        // Let everything drain before the random part.
        hold_push = 1'b1;
        wait (expected_hits.size() == 0 && !i_push);
        @(posedge i_clk);
        hold_push = 1'b0;
        for (int n = 0; n < 1600; n++) begin
            pending_items.push_back(random_item());
        end
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        wait (!i_push && expected_hits.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("segment_rect_intersect_unit_tb passed");
        end else begin
            $display("segment_rect_intersect_unit_tb failed");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("segment_rect_intersect_unit_tb failed");
        $finish;
    end

endmodule
